[hdl/sme_pkg.sv]
package sme_pkg;

	localparam int SAMPLE_W = 16;
	localparam int RECIP_W  = 24;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] REG_DELAY_STEP = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALT_POL    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIV_MODE   = 8'd3;

	localparam logic [12:0] DELAY_STEP_RST = 13'd240;
	localparam logic [5:0]  TAP_COUNT_RST  = 6'd21;

	// per-tap control that rides alongside the history read
	typedef struct packed {
		logic                zero;
		logic                use_dry;
		logic                neg;
		logic                last;
		logic [RECIP_W-1:0]  recip;
	} tap_ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ISSUE = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_LOAD  = 4'b1000
	} seq_state_t;

endpackage

[hdl/stereo_multitap_echo.sv]
// Multi-tap stereo echo. Each transaction on the slave side carries one
// left/right pair; one mixed pair leaves on the master side. A new pair waits
// until the last is through; the master side can hold it off. Each pair makes
// one history read per tap through the single read port of the history memory,
// then a short multiply/accumulate drain in the two channel lanes. History
// validity follows a fill count, so no clearing pass is needed after reset.
// Configuration must be written only while idle; the block does not enforce it.
module stereo_multitap_echo
	import sme_pkg::*;
#(
	parameter int HISTORY_DEPTH = 8192,
	parameter int MAX_TAPS      = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [31:0]            s_tdata,   // left_in[15:0], right_in[31:16]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [31:0]            m_tdata,   // left_out[15:0], right_out[31:16]
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW    = $clog2(HISTORY_DEPTH);
	localparam int KW    = $clog2(MAX_TAPS + 1);
	localparam int DW    = ((AW + 1) > 13 ? (AW + 1) : 13) + 1;
	localparam int ACC_W = SAMPLE_W + 1 + $clog2(MAX_TAPS + 1);

	logic [12:0]             step_q;
	logic [5:0]              tapc_q;
	logic                    alt_q;
	logic                    mode_q;

	seq_state_t              state_q;
	logic [KW-1:0]           taps;
	logic [KW-1:0]           k_q;
	logic [DW-1:0]           dist_q;
	logic [DW-1:0]           dist_nx;
	logic                    far_q;
	logic [AW-1:0]           wp_q;
	logic [AW:0]             fill_q;
	logic signed [15:0]      dry_l_q;
	logic signed [15:0]      dry_r_q;

	logic [31:0]             mem [HISTORY_DEPTH];
	logic [31:0]             rdata_s1;
	logic [AW:0]             rd_idx;
	logic                    issue;
	logic                    load;
	logic                    tap_v_s1;
	tap_ctrl_t               ctrl;
	tap_ctrl_t               ctrl_s1;
	logic [RECIP_W-1:0]      recip_tab [2**KW];
	logic [RECIP_W-1:0]      recip;
	logic                    done_l;
	logic                    done_r;
	logic signed [15:0]      wet_l;
	logic signed [15:0]      wet_r;
	logic                    accept;

	genvar g;
	generate
		for (g = 0; g < 2**KW; g++) begin : g_recip
			localparam longint RV = ((64'd1 << RECIP_W) + g) / (g + 1);
			assign recip_tab[g] = RECIP_W'(RV);
		end
	endgenerate

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= DELAY_STEP_RST;
			tapc_q <= TAP_COUNT_RST;
			alt_q  <= 1'b1;
			mode_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DELAY_STEP: step_q <= cfg_data[12:0];
				REG_TAP_COUNT:  tapc_q <= cfg_data[5:0];
				REG_ALT_POL:    alt_q  <= cfg_data[0];
				REG_DIV_MODE:   mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign taps = ({1'b0, tapc_q} > 7'(MAX_TAPS)) ? KW'(MAX_TAPS) : KW'(tapc_q);

	always_comb begin
		if (!mode_q) begin
			recip = recip_tab[k_q];
		end else if (k_q < KW'(16) || KW < 5) begin
			recip = {1'b1, {(RECIP_W-1){1'b0}}} >> (k_q - KW'(1));
		end else begin
			recip = '0;
		end
		ctrl.use_dry = (dist_q == '0);
		ctrl.zero    = (taps == '0) || far_q
		               || ((dist_q != '0) && (dist_q > DW'(fill_q)));
		ctrl.neg     = alt_q && k_q[0];
		ctrl.last    = (k_q >= taps);
		ctrl.recip   = recip;
	end

	assign issue   = (state_q == ST_ISSUE);
	assign dist_nx = dist_q + DW'(step_q);
	assign rd_idx  = ({1'b0, wp_q} >= dist_q[AW:0])
	                 ? ({1'b0, wp_q} - dist_q[AW:0])
	                 : ({1'b0, wp_q} + (AW+1)'(HISTORY_DEPTH) - dist_q[AW:0]);
	assign load    = (state_q == ST_LOAD) && (!m_tvalid || m_tready);

	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= mem[rd_idx[AW-1:0]];
		end
		if (load) begin
			mem[wp_q] <= {dry_r_q, dry_l_q};
		end
	end

	always_ff @(posedge clk) begin
		ctrl_s1 <= ctrl;
		if (accept) begin
			dry_l_q <= s_tdata[15:0];
			dry_r_q <= s_tdata[31:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			k_q      <= '0;
			dist_q   <= '0;
			far_q    <= 1'b0;
			wp_q     <= '0;
			fill_q   <= '0;
			tap_v_s1 <= 1'b0;
		end else begin
			tap_v_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_ISSUE;
						k_q     <= KW'(1);
						dist_q  <= DW'(step_q);
						far_q   <= (DW'(step_q) > DW'(HISTORY_DEPTH));
					end
				end
				ST_ISSUE: begin
					k_q    <= k_q + KW'(1);
					dist_q <= dist_nx;
					if (dist_nx > DW'(HISTORY_DEPTH)) begin
						far_q <= 1'b1;
					end
					if (ctrl.last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (done_l) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (load) begin
						state_q <= ST_IDLE;
						wp_q    <= (wp_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + AW'(1);
						if (fill_q != (AW+1)'(HISTORY_DEPTH)) begin
							fill_q <= fill_q + (AW+1)'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	sme_lane #(.ACC_W(ACC_W)) u_lane_l (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (accept),
		.tap_v  (tap_v_s1),
		.ctrl   (ctrl_s1),
		.smp    (rdata_s1[15:0]),
		.dry    (dry_l_q),
		.done   (done_l),
		.wet    (wet_l)
	);

	sme_lane #(.ACC_W(ACC_W)) u_lane_r (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (accept),
		.tap_v  (tap_v_s1),
		.ctrl   (ctrl_s1),
		.smp    (rdata_s1[31:16]),
		.dry    (dry_r_q),
		.done   (done_r),
		.wet    (wet_r)
	);

	sme_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.dry_l    (dry_l_q),
		.dry_r    (dry_r_q),
		.wet_l    (wet_l),
		.wet_r    (wet_r),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= (AW+1)'(HISTORY_DEPTH))
		else $error("history fill count above depth");

	a_lanes_sync: assert property (@(posedge clk) disable iff (!arst_n)
		done_l == done_r)
		else $error("channel lanes out of step");

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		done_l |-> state_q == ST_DRAIN)
		else $error("lane finished outside drain");

	a_load_advances: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> wp_q == (($past(wp_q) == AW'(HISTORY_DEPTH - 1)) ? '0 : $past(wp_q) + AW'(1)))
		else $error("write position did not advance");
`endif

endmodule

[hdl/sme_lane.sv]
module sme_lane
	import sme_pkg::*;
#(
	parameter int ACC_W = 23
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clr,
	input  logic                       tap_v,
	input  tap_ctrl_t                  ctrl,
	input  logic signed [SAMPLE_W-1:0] smp,
	input  logic signed [SAMPLE_W-1:0] dry,
	output logic                       done,
	output logic signed [SAMPLE_W-1:0] wet
);

	logic signed [SAMPLE_W:0]          x;
	logic signed [SAMPLE_W:0]          xs;
	logic [SAMPLE_W-1:0]               mag;
	logic [SAMPLE_W+RECIP_W-1:0]       prod_s2;
	logic                              sgn_s2;
	logic                              v_s2;
	logic                              last_s2;
	logic [SAMPLE_W-1:0]               q;
	logic signed [ACC_W-1:0]           term;
	logic signed [ACC_W-1:0]           acc_q;
	logic                              done_q;

	always_comb begin
		if (ctrl.zero) begin
			x = '0;
		end else if (ctrl.use_dry) begin
			x = {dry[SAMPLE_W-1], dry};
		end else begin
			x = {smp[SAMPLE_W-1], smp};
		end
		xs  = ctrl.neg ? -x : x;
		mag = xs[SAMPLE_W] ? SAMPLE_W'(-xs) : xs[SAMPLE_W-1:0];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= {{RECIP_W{1'b0}}, mag} * {{SAMPLE_W{1'b0}}, ctrl.recip};
		sgn_s2  <= xs[SAMPLE_W];
		last_s2 <= ctrl.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= tap_v;
		end
	end

	// reciprocal is scaled by 2^RECIP_W and exact for 16-bit magnitudes
	assign q    = prod_s2[RECIP_W +: SAMPLE_W];
	assign term = sgn_s2 ? -ACC_W'(q) : ACC_W'(q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= v_s2 && last_s2;
			if (clr) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= acc_q + term;
			end
		end
	end

	always_comb begin
		if (acc_q > ACC_W'(32767)) begin
			wet = 16'sh7fff;
		end else if (acc_q < -ACC_W'(32768)) begin
			wet = 16'sh8000;
		end else begin
			wet = acc_q[SAMPLE_W-1:0];
		end
	end

	assign done = done_q;

endmodule

[hdl/sme_mix.sv]
module sme_mix
	import sme_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  logic signed [SAMPLE_W-1:0] dry_l,
	input  logic signed [SAMPLE_W-1:0] dry_r,
	input  logic signed [SAMPLE_W-1:0] wet_l,
	input  logic signed [SAMPLE_W-1:0] wet_r,
	input  logic                       m_tready,
	output logic                       m_tvalid,
	output logic [2*SAMPLE_W-1:0]      m_tdata
);

	logic signed [SAMPLE_W:0]   sum_l;
	logic signed [SAMPLE_W:0]   sum_r;
	logic signed [SAMPLE_W:0]   half_l;
	logic signed [SAMPLE_W:0]   half_r;
	logic [2*SAMPLE_W-1:0]      data_q;
	logic                       valid_q;

	// halve with truncation toward zero
	always_comb begin
		sum_l  = (SAMPLE_W+1)'(dry_l) + (SAMPLE_W+1)'(wet_l);
		sum_r  = (SAMPLE_W+1)'(dry_r) + (SAMPLE_W+1)'(wet_r);
		half_l = (sum_l + (SAMPLE_W+1)'(sum_l[SAMPLE_W])) >>> 1;
		half_r = (sum_r + (SAMPLE_W+1)'(sum_r[SAMPLE_W])) >>> 1;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= {half_r[SAMPLE_W-1:0], half_l[SAMPLE_W-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule

[test/stereo_multitap_echo_tb.sv]
`timescale 1ns / 1ps

module stereo_multitap_echo_tb;
	import sme_pkg::*;

	localparam int DEPTH = 8192;
	localparam int TAP_LIMIT = 32;
	localparam int QUIET_LIMIT = 8000;
	localparam int SETTLE_CYCLES = 60;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [31:0]           s_tdata = '0;   // left_in[15:0], right_in[31:16]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [31:0]           m_tdata;        // left_out[15:0], right_out[31:16]
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	stereo_multitap_echo dut (.*);

	// predictor state
	logic [12:0] step_q = 13'd240;
	logic [5:0]  taps_q = 6'd21;
	logic        alt_q = 1'b1;
	logic        pow2_q = 1'b0;
	logic signed [15:0] past_left [DEPTH];
	logic signed [15:0] past_right [DEPTH];
	int unsigned slot = 0;

	logic [31:0] pending_pairs [$];
	logic [31:0] mix_expected [$];
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int reg_writes = 0;

	function automatic int echo_term(int sample, int k, bit neg);
		int s;
		s = neg ? -sample : sample;
		if (pow2_q) begin
			if (k >= 16)
				return 0;
			return s / (1 << k);
		end
		return s / (k + 1);
	endfunction

	function automatic logic [31:0] echo_mix(logic [31:0] pair);
		int dl, dr, wl, wr, taps, tap_dist, idx, sl, sr;
		logic [15:0] ol, orr;
		dl = $signed(pair[15:0]);
		dr = $signed(pair[31:16]);
		wl = 0;
		wr = 0;
		taps = (taps_q > TAP_LIMIT) ? TAP_LIMIT : taps_q;
		for (int k = 1; k <= taps; k++) begin
			tap_dist = k * step_q;
			if (tap_dist > DEPTH)
				continue;
			if (tap_dist == 0) begin
				sl = dl;
				sr = dr;
			end else begin
				idx = (slot + DEPTH - tap_dist) % DEPTH;
				sl = past_left[idx];
				sr = past_right[idx];
			end
			wl += echo_term(sl, k, alt_q && k[0]);
			wr += echo_term(sr, k, alt_q && k[0]);
		end
		wl = (wl > 32767) ? 32767 : (wl < -32768) ? -32768 : wl;
		wr = (wr > 32767) ? 32767 : (wr < -32768) ? -32768 : wr;
		ol = 16'((dl + wl) / 2);
		orr = 16'((dr + wr) / 2);
		past_left[slot] = pair[15:0];
		past_right[slot] = pair[31:16];
		slot = (slot + 1) % DEPTH;
		return {orr, ol};
	endfunction

	initial begin
		forever #10 clk = ~clk;
	end

	// sender: bursts with random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				mix_expected.push_back(echo_mix(s_tdata));
				items_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending_pairs.size() > 0) begin
					s_tdata <= pending_pairs.pop_front();
					s_tvalid <= 1'b1;
					if (burst_left > 0)
						burst_left--;
					else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks results, stalls on its own pattern, one long hold-off
	int hold_left = 0;
	bit hold_done = 0;
	int stall_mode = 0;
	int stall_phase = 0;
	always @(posedge clk) begin
		logic ready_next;
		logic [31:0] want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (mix_expected.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %h", m_tdata);
				end else begin
					want = mix_expected.pop_front();
					if (want[15:0] !== m_tdata[15:0] || want[31:16] !== m_tdata[31:16]) begin
						errors++;
						if (errors <= 10)
							$display("result %0d: left exp %0d got %0d, right exp %0d got %0d",
								results_seen, $signed(want[15:0]), $signed(m_tdata[15:0]),
								$signed(want[31:16]), $signed(m_tdata[31:16]));
					end
				end
			end
			if (++stall_phase == 97) begin
				stall_phase = 0;
				stall_mode = $urandom_range(0, 2);
			end
			if (hold_left > 0) begin
				hold_left--;
				ready_next = 1'b0;
			end else if (results_seen >= 300 && !hold_done) begin
				hold_done = 1;
				hold_left = 1500;
				ready_next = 1'b0;
			end else begin
				case (stall_mode)
					0: ready_next = 1'b1;
					1: ready_next = ($urandom_range(0, 9) > 2);
					default: ready_next = ($urandom_range(0, 9) > 7);
				endcase
			end
			m_tready <= ready_next;
		end
	end

	// watchdog on cycles with no transaction at all
	int quiet = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else if (++quiet == QUIET_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		cfg_valid <= 1'b0;
		reg_writes++;
		case (idx)
			REG_DELAY_STEP: step_q = val[12:0];
			REG_TAP_COUNT:  taps_q = val[5:0];
			REG_ALT_POL:    alt_q = val[0];
			REG_DIV_MODE:   pow2_q = val[0];
			default: ;
		endcase
	endtask

	task automatic set_echo(int step, int taps, bit alt, bit pow2);
		write_reg(REG_DELAY_STEP, 13'(step));
		write_reg(REG_TAP_COUNT, 13'(taps));
		write_reg(REG_ALT_POL, 13'(alt));
		write_reg(REG_DIV_MODE, 13'(pow2));
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_pairs.size() != 0 || s_tvalid || mix_expected.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hffff;
			4: return 16'($signed($urandom_range(0, 600)) - 300);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic queue_pair(logic [15:0] l, logic [15:0] r);
		pending_pairs.push_back({r, l});
	endtask

	initial begin
		int step, taps;
		for (int i = 0; i < DEPTH; i++) begin
			past_left[i] = '0;
			past_right[i] = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// reset settings, field extremes
		queue_pair(16'h7fff, 16'h8000);
		queue_pair(16'h8000, 16'h7fff);
		queue_pair(16'h0000, 16'hffff);
		queue_pair(16'hffff, 16'h0001);
		queue_pair(16'h7fff, 16'h7fff);
		queue_pair(16'h8000, 16'h8000);
		wait_drained();

		// step 1, tap count above the limit, no alternation: wet clamps
		set_echo(1, 63, 0, 0);
		repeat (5) queue_pair(16'h7fff, 16'h8000);
		wait_drained();
		set_echo(1, 32, 1, 1);
		repeat (4) queue_pair(16'h8000, 16'h7fff);
		wait_drained();
		// zero step reads the current pair; zero taps leave it dry
		set_echo(0, 5, 0, 0);
		queue_pair(16'h7fff, 16'h8000);
		queue_pair(16'h1234, 16'hedcb);
		wait_drained();
		set_echo(3, 0, 1, 0);
		queue_pair(16'h8000, 16'h7fff);
		queue_pair(16'h4321, 16'h8001);
		wait_drained();
		// taps at and beyond the history depth
		set_echo(4096, 3, 1, 0);
		queue_pair(16'h7fff, 16'h8000);
		queue_pair(16'hffff, 16'h0000);
		wait_drained();

		for (int ph = 0; ph < 12; ph++) begin
			case ($urandom_range(0, 7))
				0: step = 0;
				1: step = 1;
				2: step = 8191;
				3: step = $urandom_range(1, 8191);
				default: step = $urandom_range(1, 40);
			endcase
			case ($urandom_range(0, 5))
				0: taps = 0;
				1: taps = 1;
				2: taps = 32;
				3: taps = 63;
				default: taps = $urandom_range(0, 63);
			endcase
			set_echo(step, taps, $urandom_range(0, 1), $urandom_range(0, 1));
			repeat (85) queue_pair(pick_sample(), pick_sample());
			wait_drained();
		end

		if (mix_expected.size() != 0)
			errors += mix_expected.size();
		$display("%0d pairs in, %0d results checked, %0d register writes", items_sent,
			results_seen, reg_writes);
		$display("covered zero/large steps, 0..63 taps, both polarity and divider modes");
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
